// File: rtl/cops_pkg.sv
// Package for the clamped one-pole parameter smoother: widths, codes and item types.
`default_nettype none

package cops_pkg;

  // Level width (signed fixed point) and coefficient fraction bits.
  localparam int ValueWidth   = 32;
  localparam int CoefFracBits = 16;
  localparam int CoefWidth    = CoefFracBits + 1;

  // Configuration data carries the wider of a level and a coefficient.
  localparam int CfgDataWidth = (ValueWidth > CoefFracBits) ? ValueWidth : CoefWidth;
  localparam int CfgIdxWidth  = 2;

  // Full-scale coefficient (1.0).
  localparam logic [CoefWidth-1:0] CoefOne = CoefWidth'(1) << CoefFracBits;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_STEP       = 2'd0,
    OP_SET_TARGET = 2'd1,
    OP_RESET      = 2'd2
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ALPHA      = 2'd0,
    CFG_RANGE_LOW  = 2'd1,
    CFG_RANGE_HIGH = 2'd2
  } cfg_reg_e;

  // Input item.
  typedef struct packed {
    logic [1:0]                   op;
    logic signed [ValueWidth-1:0] operand_value;
  } cops_in_t;

  // Result item.
  typedef struct packed {
    logic signed [ValueWidth-1:0] smoothed_value;
    logic                         bypassed;
  } cops_out_t;

  // Configuration as seen by the datapath: ordered bounds and coefficient.
  typedef struct packed {
    logic [CoefFracBits-1:0]      alpha_frac;
    logic                         full_scale;
    logic signed [ValueWidth-1:0] bound_lo;
    logic signed [ValueWidth-1:0] bound_hi;
  } cops_cfg_t;

endpackage

`default_nettype wire

// File: rtl/cops_cfg_regs.sv
// Configuration registers of the smoother, with bound ordering and full-scale detect.
`default_nettype none

module cops_cfg_regs (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [cops_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  wire logic [cops_pkg::CfgDataWidth-1:0]    cfg_data_i,
  output cops_pkg::cops_cfg_t                       cfg_o
);

  localparam int W  = cops_pkg::ValueWidth;
  localparam int F  = cops_pkg::CoefFracBits;
  localparam int CW = cops_pkg::CoefWidth;

  logic [CW-1:0]       alpha_q;
  logic signed [W-1:0] low_q;
  logic signed [W-1:0] high_q;
  logic                swap;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Register file with reset to full-scale coefficient and full range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= cops_pkg::CoefOne;
      low_q   <= {1'b1, {(W-1){1'b0}}};
      high_q  <= {1'b0, {(W-1){1'b1}}};
    end else if (cfg_valid_i) begin
      unique case (cops_pkg::cfg_reg_e'(cfg_index_i))
        cops_pkg::CFG_ALPHA:      alpha_q <= cfg_data_i[CW-1:0];
        cops_pkg::CFG_RANGE_LOW:  low_q   <= cfg_data_i[W-1:0];
        cops_pkg::CFG_RANGE_HIGH: high_q  <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  // Put the bounds in order; a coefficient at or above 1.0 bypasses smoothing.
  assign swap               = low_q > high_q;
  assign cfg_o.bound_lo     = swap ? high_q : low_q;
  assign cfg_o.bound_hi     = swap ? low_q : high_q;
  assign cfg_o.full_scale   = alpha_q >= cops_pkg::CoefOne;
  assign cfg_o.alpha_frac   = alpha_q[F-1:0];

endmodule

`default_nettype wire

// File: rtl/cops_datapath.sv
// Level state, one-pole update, clamp and result register of the smoother.
`default_nettype none

module cops_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire cops_pkg::cops_in_t   item_i,
  input  wire cops_pkg::cops_cfg_t  cfg_i,
  output cops_pkg::cops_out_t       result_o
);

  localparam int W  = cops_pkg::ValueWidth;
  localparam int F  = cops_pkg::CoefFracBits;
  localparam int PW = W + F + 2;

  logic signed [W-1:0]  current_q, current_d;
  logic signed [W-1:0]  target_q, target_d;
  cops_pkg::cops_out_t  result_q, result_d;

  logic signed [W:0]    diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_shifted;
  logic signed [W:0]    next_step;
  logic signed [W-1:0]  step_clamped;
  logic signed [W-1:0]  operand_clamped;

  // Clamp a value one bit wider than a level into the ordered bounds.
  function automatic logic signed [W-1:0] clamp_level(input logic signed [W:0]   v,
                                                      input logic signed [W-1:0] lo,
                                                      input logic signed [W-1:0] hi);
    logic signed [W:0] lo_x;
    logic signed [W:0] hi_x;
    lo_x = (W+1)'(lo);
    hi_x = (W+1)'(hi);
    if (v < lo_x) begin
      return lo;
    end else if (v > hi_x) begin
      return hi;
    end
    return v[W-1:0];
  endfunction

  // Step: current + floor(alpha * (target - current) / 2^F), then clamp.
  assign diff         = (W+1)'(target_q) - (W+1)'(current_q);
  assign prod         = PW'(diff) * PW'(signed'({1'b0, cfg_i.alpha_frac}));
  assign prod_shifted = prod >>> F;
  assign next_step    = (W+1)'(current_q) + prod_shifted[W:0];
  assign step_clamped = clamp_level(next_step, cfg_i.bound_lo, cfg_i.bound_hi);

  // Operand clamp for set-target and reset items.
  assign operand_clamped = clamp_level((W+1)'(item_i.operand_value),
                                       cfg_i.bound_lo, cfg_i.bound_hi);

  // Next state and result for the item leaving the input register.
  always_comb begin
    current_d = current_q;
    target_d  = target_q;
    result_d.bypassed = cfg_i.full_scale || (current_q == target_q);
    unique case (item_i.op)
      cops_pkg::OP_STEP: begin
        if (cfg_i.full_scale || (current_q == target_q)) begin
          current_d = target_q;
        end else begin
          current_d = step_clamped;
        end
      end
      cops_pkg::OP_SET_TARGET: begin
        target_d          = operand_clamped;
        result_d.bypassed = cfg_i.full_scale || (current_q == operand_clamped);
      end
      cops_pkg::OP_RESET: begin
        current_d         = operand_clamped;
        target_d          = operand_clamped;
        result_d.bypassed = 1'b1;
      end
      default: ;
    endcase
    result_d.smoothed_value = current_d;
  end

  // Levels reset to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_q <= '0;
      target_q  <= '0;
    end else if (load_i) begin
      current_q <= current_d;
      target_q  <= target_d;
    end
  end

  // Result register holds its item until the next load.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

// File: rtl/clamped_one_pole_param_smoother.sv
// Top level of the clamped one-pole parameter smoother: handshake and stage control.
//
//   Channel   Direction  Handshake                  Payload
//   in        sink       in_valid_i / in_stall_o     in_item_i   (op, operand_value)
//   out       source     out_valid_o / out_stall_i   out_item_o  (smoothed_value, bypassed)
//   cfg       sink       cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled; a result passes through
// the input register and then the result register before it is on the output.
// The multiply, add and clamp of a step resolve combinationally while the item
// moves from the input register to the result register, so the level recurrence closes
// through the one 33x17 multiplier and the clamp compare.
// Reset clears both levels to zero, sets alpha to full scale and the range to full span.
// An output stall holds the result; the input stalls only when both registers are full
// and the output is stalled.
`default_nettype none

module clamped_one_pole_param_smoother (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire cops_pkg::cops_in_t                   in_item_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output cops_pkg::cops_out_t                       out_item_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [cops_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  wire logic [cops_pkg::CfgDataWidth-1:0]    cfg_data_i
);

  cops_pkg::cops_cfg_t cfg;
  cops_pkg::cops_in_t  s1_item_q;
  logic                s1_valid_q, s1_valid_d;
  logic                out_valid_q, out_valid_d;
  logic                advance;
  logic                load;
  logic                in_accept;

  // Configuration registers.
  cops_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Stage control: the result register frees up when empty or when its item is taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign load       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d  = in_accept || (s1_valid_q && !load);
    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
    end
  end

  // Level update and result register.
  cops_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (out_item_o)
  );

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // An empty input register never holds off the producer.
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");

  // A full pipeline behind a stalled output must stall the input.
  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input not stalled while both registers are full");

  // A full-scale coefficient always reports a bypassed result.
  a_full_scale_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && cfg.full_scale) |=> out_item_o.bypassed)
    else $error("full-scale coefficient gave an unbypassed result");

  // A reset item leaves current equal to target, so it reports bypassed.
  a_reset_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (s1_item_q.op == cops_pkg::OP_RESET)) |=> out_item_o.bypassed)
    else $error("reset item gave an unbypassed result");

  // A result is loaded only into a free result register.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire
